// File: rtl/core/blkc_pkg.sv
// Shared types and constants for the block cache aging replacement engine.
package blkc_pkg;

	localparam int AGE_W = 8;
	localparam int SLOT_FIELD_W = 3;
	localparam int OUT_DATA_W = 8;

	localparam logic [AGE_W-1:0] AGE_START_RESET = 8'd100;
	localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_PROBE = 1'b1;

	typedef struct packed {
		logic load;
		logic exec;
	} blkc_cmd_t;

endpackage

// File: rtl/core/blkc_ctrl.sv
// Controller state machine that sequences request capture, lookup and result handoff.
module blkc_ctrl
	import blkc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output blkc_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec = (state_q == ST_LOOKUP) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/blkc_dp.sv
// Datapath with slot tags, valid bits, aging counters, victim selection and result register.
module blkc_dp
	import blkc_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int BLOCK_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  blkc_cmd_t             cmd,
	input  logic                  req_cmd,
	input  logic [BLOCK_BITS-1:0] req_block,
	input  logic                  cfg_we,
	input  logic [AGE_W-1:0]      cfg_data,
	output logic [OUT_DATA_W-1:0] result
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic                  req_cmd_q;
	logic [BLOCK_BITS-1:0] req_block_q;
	logic [AGE_W-1:0]      age_start_q;
	logic [BLOCK_BITS-1:0] tag_q [SLOTS];
	logic [AGE_W-1:0]      age_q [SLOTS];
	logic [SLOTS-1:0]      valid_q;
	logic [OUT_DATA_W-1:0] result_q;

	logic             hit_found;
	logic [IDX_W-1:0] hit_idx;
	logic             have_empty;
	logic [IDX_W-1:0] empty_idx;
	logic [AGE_W-1:0] min_age;
	logic [IDX_W-1:0] oldest_idx;
	logic [IDX_W-1:0] victim_idx;
	logic [IDX_W-1:0] sel_idx;
	logic             res_hit;
	logic             res_fill;
	logic [SLOT_FIELD_W-1:0] res_slot;

	function automatic logic [AGE_W-1:0] age_dec(input logic [AGE_W-1:0] a);
		return (a != '0) ? a - 1'b1 : a;
	endfunction

	always_comb begin
		hit_found = 1'b0;
		hit_idx = '0;
		have_empty = 1'b0;
		empty_idx = '0;
		min_age = AGE_MAX;
		oldest_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (!hit_found && valid_q[i] && (tag_q[i] == req_block_q)) begin
				hit_found = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				have_empty = 1'b1;
				empty_idx = IDX_W'(i);
			end else if (age_q[i] < min_age) begin
				min_age = age_q[i];
				oldest_idx = IDX_W'(i);
			end
		end
		victim_idx = have_empty ? empty_idx : oldest_idx;
		res_hit = hit_found;
		res_fill = (req_cmd_q == OP_LOOKUP) && !hit_found;
		if (hit_found) begin
			sel_idx = hit_idx;
		end else if (req_cmd_q == OP_LOOKUP) begin
			sel_idx = victim_idx;
		end else begin
			sel_idx = '0;
		end
		res_slot = SLOT_FIELD_W'(sel_idx);
	end

	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_start_q <= AGE_START_RESET;
			valid_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				tag_q[i] <= '0;
				age_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				age_start_q <= cfg_data;
			end
			if (cmd.exec && (req_cmd_q == OP_LOOKUP)) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (hit_found && (hit_idx == IDX_W'(i))) begin
						age_q[i] <= age_dec(age_start_q);
					end else if (!hit_found && (victim_idx == IDX_W'(i))) begin
						age_q[i] <= age_start_q;
						tag_q[i] <= req_block_q;
						valid_q[i] <= 1'b1;
					end else begin
						age_q[i] <= age_dec(age_q[i]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_cmd_q <= req_cmd;
			req_block_q <= req_block;
		end
		if (cmd.exec) begin
			result_q <= {{(OUT_DATA_W - SLOT_FIELD_W - 2){1'b0}}, res_fill, res_slot, res_hit};
		end
	end

endmodule

// File: rtl/core/block_cache_aging_replacement.sv
// Top level of the block cache aging replacement engine.
// A request is captured in ST_IDLE; ST_LOOKUP then does lookup, victim choice and update.
// A new request is taken only after the previous lookup ends; a stalled result holds the lookup.
// A result waits in an output register, and the next request is accepted meanwhile.
// Reset is asynchronous and active low: all slots become empty with age zero, age_start is 100.
// Configuration writes are taken in any cycle.
module block_cache_aging_replacement
	import blkc_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int BLOCK_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [((BLOCK_BITS+7)/8)*8-1:0]   s_tdata,  // block
	input  logic                              s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_DATA_W-1:0]             m_tdata,  // hit, slot, fill_needed
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [AGE_W-1:0]                  cfg_data
);

	blkc_cmd_t cmd;

	assign cfg_ready = 1'b1;

	blkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	blkc_dp #(
		.SLOTS      (SLOTS),
		.BLOCK_BITS (BLOCK_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_cmd   (s_tuser),
		.req_block (s_tdata[BLOCK_BITS-1:0]),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.result    (m_tdata)
	);

endmodule

// File: rtl/core/blkc_checker.sv
// Port-level checker for the block cache aging replacement engine and its bind.
module blkc_checker
	import blkc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_fill_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[0])
		else $error("A fill request was flagged on a hit.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_DATA_W-1:5] == '0))
		else $error("Result word padding is not zero.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("A second request was taken before the lookup ran.");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("A stalled result word changed or dropped.");

endmodule

bind block_cache_aging_replacement blkc_checker u_blkc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
